// File: hw/rtl/lpw_pkg.sv
`default_nettype none
package lpw_pkg;

   localparam int unsigned MAX_MODULUS = 128;
   localparam int unsigned VAL_W       = 7;
   localparam int unsigned MULT_W      = 7;
   localparam int unsigned INC_W       = 7;
   localparam int unsigned MOD_W       = 8;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned POS_W       = 8;
   localparam int unsigned CSR_W       = 8;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned ADDR_W      = $clog2(MAX_MODULUS);
   // a*x+c stays below 2^14 for 7-bit operands
   localparam int unsigned SUM_W       = MULT_W + VAL_W;
   localparam int unsigned DIVD_W      = VAL_W + FRAC_W;
   localparam int unsigned CNT_W       = $clog2(DIVD_W + 1);
   localparam int unsigned EPOCH_W     = 4;

   localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(17);
   localparam logic [INC_W-1:0]  INC_RESET  = INC_W'(43);
   localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_W'(100);
   localparam logic [MOD_W-1:0]  MOD_MIN    = MOD_W'(2);
   localparam logic [MOD_W-1:0]  MOD_MAX    = MOD_W'(MAX_MODULUS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MULTIPLIER = 2'd0,
      CSR_INCREMENT  = 2'd1,
      CSR_MODULUS    = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_RESTART = 1'b0,
      MODE_STEP    = 1'b1
   } mode_type;

endpackage
`default_nettype wire

// File: hw/rtl/lcg_period_walker.sv
// Linear congruential generator that walks one run and detects where it closes.
// Input channel req_*: mode 0 restarts from req_seed, mode 1 advances one step.
// Result channel rsp_*: exactly one item per input item (value, Q0.16 fraction of
// value/modulus, position, cycle_closed, seed_error). csr_* writes multiplier,
// increment and modulus; write only while the block is idle.
// From accept to rsp_valid: a restart or a step after closure runs the fraction division
// and loads the output register; a live step first works (a*x+c) mod m in remainder steps,
// looks the new value up in the map (ST_LOOK, ST_CHECK), then does the same.
// A new item is taken only once the last one has reached the output register. Both
// divisions go through one shared restoring divider that retires one bit per cycle.
// A restart that wraps the 4-bit run epoch of the visited map adds a sweep of the whole
// map, once every 15 restarts. After reset the block sweeps the map with req_ready low;
// configuration writes are taken during that time.
// The result sits in an output register: while the receiver stalls the block
// still accepts and works the next item, then holds until the register frees.
`default_nettype none
module lcg_period_walker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_mode,
   input  wire logic [lpw_pkg::VAL_W-1:0]    req_seed,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [lpw_pkg::VAL_W-1:0]         rsp_value,
   output logic [lpw_pkg::FRAC_W-1:0]        rsp_fraction,
   output logic [lpw_pkg::POS_W-1:0]         rsp_position,
   output logic                              rsp_cycle_closed,
   output logic                              rsp_seed_error,
   input  wire logic                         csr_we,
   input  wire logic [lpw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lpw_pkg::CSR_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MOD,
      ST_LOOK,
      ST_CHECK,
      ST_FRAC,
      ST_DONE
   } state_type;

   localparam int unsigned VAL_W   = lpw_pkg::VAL_W;
   localparam int unsigned MOD_W   = lpw_pkg::MOD_W;
   localparam int unsigned FRAC_W  = lpw_pkg::FRAC_W;
   localparam int unsigned POS_W   = lpw_pkg::POS_W;
   localparam int unsigned ADDR_W  = lpw_pkg::ADDR_W;
   localparam int unsigned SUM_W   = lpw_pkg::SUM_W;
   localparam int unsigned DIVD_W  = lpw_pkg::DIVD_W;
   localparam int unsigned CNT_W   = lpw_pkg::CNT_W;
   localparam int unsigned EPOCH_W = lpw_pkg::EPOCH_W;

   state_type state_ff, state_in;

   logic [lpw_pkg::MULT_W-1:0] mult_ff, mult_in;
   logic [lpw_pkg::INC_W-1:0]  inc_ff, inc_in;
   logic [MOD_W-1:0]           mod_ff, mod_in;

   logic [VAL_W-1:0]   cur_ff, cur_in;
   logic [POS_W-1:0]   run_ff, run_in;
   logic               closed_ff, closed_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;

   logic [DIVD_W-1:0]  divd_ff, divd_in;
   logic [MOD_W-1:0]   rem_ff, rem_in;
   logic [FRAC_W-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [VAL_W-1:0]   res_value_ff, res_value_in;
   logic [POS_W-1:0]   res_pos_ff, res_pos_in;
   logic               res_closed_ff, res_closed_in;
   logic               res_err_ff, res_err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [FRAC_W-1:0]  rsp_fraction_ff, rsp_fraction_in;
   logic [POS_W-1:0]   rsp_position_ff, rsp_position_in;
   logic               rsp_closed_ff, rsp_closed_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [EPOCH_W-1:0] map_mem [lpw_pkg::MAX_MODULUS];
   logic [EPOCH_W-1:0] map_rd_ff;
   logic               map_we;
   logic [ADDR_W-1:0]  map_waddr;
   logic [EPOCH_W-1:0] map_wdata;

   logic [MOD_W-1:0]   m_eff;
   logic [MOD_W:0]     trial;
   logic               trial_ge;
   logic [MOD_W:0]     trial_diff;
   logic [MOD_W-1:0]   rem_next;
   logic [SUM_W-1:0]   lcg_sum;

   // clamp the modulus register into the legal range
   always_comb begin
      if (mod_ff < lpw_pkg::MOD_MIN) begin
         m_eff = lpw_pkg::MOD_MIN;
      end else if (mod_ff > lpw_pkg::MOD_MAX) begin
         m_eff = lpw_pkg::MOD_MAX;
      end else begin
         m_eff = mod_ff;
      end
   end

   // one restoring division step: shift in the next dividend bit
   assign trial      = {rem_ff, divd_ff[DIVD_W-1]};
   assign trial_ge   = trial >= {1'b0, m_eff};
   assign trial_diff = trial - {1'b0, m_eff};
   assign rem_next   = trial_ge ? trial_diff[MOD_W-1:0] : trial[MOD_W-1:0];

   assign lcg_sum = SUM_W'(mult_ff) * SUM_W'(cur_ff) + SUM_W'(inc_ff);

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_fraction     = rsp_fraction_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_cycle_closed = rsp_closed_ff;
   assign rsp_seed_error   = rsp_err_ff;

   always_comb begin
      state_in        = state_ff;
      mult_in         = mult_ff;
      inc_in          = inc_ff;
      mod_in          = mod_ff;
      cur_in          = cur_ff;
      run_in          = run_ff;
      closed_in       = closed_ff;
      epoch_in        = epoch_ff;
      sweep_in        = sweep_ff;
      divd_in         = divd_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      cnt_in          = cnt_ff;
      res_value_in    = res_value_ff;
      res_pos_in      = res_pos_ff;
      res_closed_in   = res_closed_ff;
      res_err_in      = res_err_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_fraction_in = rsp_fraction_ff;
      rsp_position_in = rsp_position_ff;
      rsp_closed_in   = rsp_closed_ff;
      rsp_err_in      = rsp_err_ff;
      map_we          = 1'b0;
      map_waddr       = cur_ff[ADDR_W-1:0];
      map_wdata       = epoch_ff;

      if (csr_we) begin
         case (csr_index)
            lpw_pkg::CSR_MULTIPLIER: mult_in = csr_wdata[lpw_pkg::MULT_W-1:0];
            lpw_pkg::CSR_INCREMENT:  inc_in  = csr_wdata[lpw_pkg::INC_W-1:0];
            lpw_pkg::CSR_MODULUS:    mod_in  = csr_wdata[MOD_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SWEEP: begin
            // the seed of a restart gets the fresh epoch, all else is cleared
            map_we    = 1'b1;
            map_waddr = sweep_ff;
            map_wdata = (sweep_ff == cur_ff[ADDR_W-1:0]) ? epoch_ff : '0;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_ff == '1) begin
               if (closed_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  divd_in  = DIVD_W'(res_value_ff) << FRAC_W;
                  rem_in   = '0;
                  cnt_in   = CNT_W'(DIVD_W);
                  state_in = ST_FRAC;
               end
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               divd_in  = DIVD_W'(cur_ff) << FRAC_W;
               rem_in   = '0;
               cnt_in   = CNT_W'(DIVD_W);
               state_in = ST_FRAC;
               if (req_mode == lpw_pkg::MODE_RESTART) begin
                  if ({1'b0, req_seed} >= m_eff) begin
                     res_value_in  = '0;
                     res_pos_in    = '0;
                     res_closed_in = 1'b0;
                     res_err_in    = 1'b1;
                     divd_in       = '0;
                  end else begin
                     cur_in        = req_seed;
                     run_in        = POS_W'(1);
                     closed_in     = 1'b0;
                     res_value_in  = req_seed;
                     res_pos_in    = '0;
                     res_closed_in = 1'b0;
                     res_err_in    = 1'b0;
                     divd_in       = DIVD_W'(req_seed) << FRAC_W;
                     if (epoch_ff == '1) begin
                        // epoch wraps: wipe the map before reuse
                        epoch_in = EPOCH_W'(1);
                        sweep_in = '0;
                        state_in = ST_SWEEP;
                     end else begin
                        epoch_in  = epoch_ff + EPOCH_W'(1);
                        map_we    = 1'b1;
                        map_waddr = req_seed[ADDR_W-1:0];
                        map_wdata = epoch_ff + EPOCH_W'(1);
                     end
                  end
               end else if (closed_ff) begin
                  res_value_in  = cur_ff;
                  res_pos_in    = run_ff;
                  res_closed_in = 1'b1;
                  res_err_in    = 1'b0;
               end else begin
                  divd_in  = DIVD_W'(lcg_sum) << (DIVD_W - SUM_W);
                  cnt_in   = CNT_W'(SUM_W);
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            divd_in = divd_ff << 1;
            rem_in  = rem_next;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               cur_in   = rem_next[VAL_W-1:0];
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            res_value_in = cur_ff;
            res_pos_in   = run_ff;
            res_err_in   = 1'b0;
            if (map_rd_ff == epoch_ff) begin
               closed_in     = 1'b1;
               res_closed_in = 1'b1;
            end else begin
               map_we        = 1'b1;
               res_closed_in = 1'b0;
               run_in        = run_ff + POS_W'(1);
            end
            divd_in  = DIVD_W'(cur_ff) << FRAC_W;
            rem_in   = '0;
            cnt_in   = CNT_W'(DIVD_W);
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            divd_in = divd_ff << 1;
            rem_in  = rem_next;
            quot_in = {quot_ff[FRAC_W-2:0], trial_ge};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = res_value_ff;
               rsp_fraction_in = quot_ff;
               rsp_position_in = res_pos_ff;
               rsp_closed_in   = res_closed_ff;
               rsp_err_in      = res_err_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         mult_ff      <= lpw_pkg::MULT_RESET;
         inc_ff       <= lpw_pkg::INC_RESET;
         mod_ff       <= lpw_pkg::MOD_RESET;
         cur_ff       <= '0;
         run_ff       <= '0;
         closed_ff    <= 1'b1;
         epoch_ff     <= '0;
         sweep_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mult_ff      <= mult_in;
         inc_ff       <= inc_in;
         mod_ff       <= mod_in;
         cur_ff       <= cur_in;
         run_ff       <= run_in;
         closed_ff    <= closed_in;
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      divd_ff         <= divd_in;
      rem_ff          <= rem_in;
      quot_ff         <= quot_in;
      res_value_ff    <= res_value_in;
      res_pos_ff      <= res_pos_in;
      res_closed_ff   <= res_closed_in;
      res_err_ff      <= res_err_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_fraction_ff <= rsp_fraction_in;
      rsp_position_ff <= rsp_position_in;
      rsp_closed_ff   <= rsp_closed_in;
      rsp_err_ff      <= rsp_err_in;
   end

   // visited map: each entry holds the epoch of the run that last marked it
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[cur_ff[ADDR_W-1:0]];
   end

endmodule
`default_nettype wire
